// File: rtl/dsdo_pkg.sv
`timescale 1ns / 1ps

package dsdo_pkg;

   localparam logic [11:0] FIRST_YEAR       = 12'd1900;
   localparam logic [11:0] LAST_YEAR        = 12'd2099;
   localparam logic [7:0]  DEFAULT_YEAR_IDX = 8'd100;
   localparam logic [7:0]  LAST_YEAR_IDX    = 8'd199;
   localparam logic [16:0] MAX_SERIAL       = 17'd73049;
   localparam logic [16:0] DAYS_PER_YEAR    = 17'd365;

   // Reciprocal of 365 scaled by 2**26, rounded up; exact for counts below 2**17.
   localparam logic [17:0] RECIP_365        = 18'd183860;
   localparam int          RECIP_SHIFT      = 26;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_MAY = 4'd5;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_JUL = 4'd7;
   localparam logic [3:0] MONTH_AUG = 4'd8;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_OCT = 4'd10;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [16:0] rem;
      logic [16:0] serial;
      logic        saturated;
   } dsdo_days_type;

   typedef struct packed {
      logic [16:0] serial_day;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic        saturated;
   } dsdo_result_type;

   // The index counts years from 1900; 1900 itself is not a leap year.
   function automatic logic year_leap(input logic [7:0] idx);
      year_leap = (idx[1:0] == 2'd0) && (idx != 8'd0);
   endfunction

   function automatic logic [5:0] leap_days(input logic [7:0] idx);
      logic [7:0] prev;
      prev = idx - 8'd1;
      leap_days = (idx == 8'd0) ? 6'd0 : prev[7:2];
   endfunction

   function automatic logic [16:0] year_start(input logic [7:0] idx);
      year_start = 17'(idx) * DAYS_PER_YEAR + 17'(leap_days(idx));
   endfunction

   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      case (month)
         MONTH_JAN: base = 9'd0;
         MONTH_FEB: base = 9'd31;
         MONTH_MAR: base = 9'd59;
         MONTH_APR: base = 9'd90;
         MONTH_MAY: base = 9'd120;
         MONTH_JUN: base = 9'd151;
         MONTH_JUL: base = 9'd181;
         MONTH_AUG: base = 9'd212;
         MONTH_SEP: base = 9'd243;
         MONTH_OCT: base = 9'd273;
         MONTH_NOV: base = 9'd304;
         MONTH_DEC: base = 9'd334;
         default:   base = 9'd0;
      endcase
      month_start = (leap && month > MONTH_FEB) ? base + 9'd1 : base;
   endfunction

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      case (month)
         MONTH_FEB: days_in_month = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days_in_month = 5'd30;
         default:   days_in_month = 5'd31;
      endcase
   endfunction

endpackage

// File: rtl/dsdo_req_if.sv
`timescale 1ns / 1ps

interface dsdo_req_if;
   logic               valid;
   logic               ready;
   logic [11:0]        year_in;
   logic [3:0]         month_in;
   logic [5:0]         day_in;
   logic signed [17:0] day_offset;

   modport source (output valid, output year_in, output month_in, output day_in,
                   output day_offset, input ready);
   modport sink (input valid, input year_in, input month_in, input day_in,
                 input day_offset, output ready);
endinterface

// File: rtl/dsdo_rsp_if.sv
`timescale 1ns / 1ps

interface dsdo_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] serial_day;
   logic [11:0] year_out;
   logic [3:0]  month_out;
   logic [4:0]  day_out;
   logic        saturated;

   modport source (output valid, output serial_day, output year_out, output month_out,
                   output day_out, output saturated, input ready);
   modport sink (input valid, input serial_day, input year_out, input month_out,
                 input day_out, input saturated, output ready);
endinterface

// File: rtl/date_serial_day_offset.sv
`timescale 1ns / 1ps

// Channel   Port      Direction  Payload
// request   req_chan  sink       year_in, month_in, day_in, day_offset
// response  rsp_chan  source     serial_day, year_out, month_out, day_out, saturated
//
// One transaction per cycle sustained while the response side is ready. Each result
// passes through seven register stages: repair, serial sum, offset and clamp,
// year estimate by reciprocal multiply, year start, year correction, month and day.
// Reset clears only the stage valid bits. A stage takes a new transaction whenever it
// is empty or the stage after it moves, so a stall holds every transaction in place.

module date_serial_day_offset (
   input logic        clock,
   input logic        reset,
   dsdo_req_if.sink   req_chan,
   dsdo_rsp_if.source rsp_chan
);
   import dsdo_pkg::*;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic               s1_ready, s2_ready, s3_ready, dec_ready;

   logic               s1_year_ok, s1_month_ok, s1_day_ok;
   logic [7:0]         s1_idx_in, s1_idx_ff;
   logic [3:0]         s1_month_in, s1_month_ff;
   logic [4:0]         s1_dim;
   logic [4:0]         s1_day_in, s1_day_ff;
   logic               s1_leap_in, s1_leap_ff;
   logic signed [17:0] s1_offset_ff;

   logic [16:0]        s2_serial_in, s2_serial_ff;
   logic signed [17:0] s2_offset_ff;

   logic signed [18:0] s3_sum;
   dsdo_days_type      s3_days_in, s3_days_ff;

   dsdo_result_type    dec_result;
   logic               dec_valid;

   assign s3_ready      = ~s3_valid_ff | dec_ready;
   assign s2_ready      = ~s2_valid_ff | s3_ready;
   assign s1_ready      = ~s1_valid_ff | s2_ready;
   assign req_chan.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_chan.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // The year is repaired first, so the day is checked against the repaired year.
   always_comb begin
      s1_year_ok  = (req_chan.year_in >= FIRST_YEAR) && (req_chan.year_in <= LAST_YEAR);
      s1_idx_in   = s1_year_ok ? 8'(req_chan.year_in - FIRST_YEAR) : DEFAULT_YEAR_IDX;
      s1_leap_in  = year_leap(s1_idx_in);
      s1_month_ok = (req_chan.month_in >= MONTH_JAN) && (req_chan.month_in <= MONTH_DEC);
      s1_month_in = s1_month_ok ? req_chan.month_in : MONTH_JAN;
      s1_dim      = days_in_month(s1_month_in, s1_leap_in);
      s1_day_ok   = (req_chan.day_in != 6'd0) && (req_chan.day_in <= {1'b0, s1_dim});
      s1_day_in   = s1_day_ok ? req_chan.day_in[4:0] : 5'd1;
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         s1_idx_ff    <= s1_idx_in;
         s1_month_ff  <= s1_month_in;
         s1_day_ff    <= s1_day_in;
         s1_leap_ff   <= s1_leap_in;
         s1_offset_ff <= req_chan.day_offset;
      end
   end

   assign s2_serial_in = year_start(s1_idx_ff) + 17'(month_start(s1_month_ff, s1_leap_ff))
                         + 17'(s1_day_ff);

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_serial_ff <= s2_serial_in;
         s2_offset_ff <= s1_offset_ff;
      end
   end

   always_comb begin
      s3_sum            = $signed({2'b00, s2_serial_ff}) + 19'(s2_offset_ff);
      s3_days_in.serial = s2_serial_ff;
      if (s3_sum < 19'sd1) begin
         s3_days_in.rem       = 17'd0;
         s3_days_in.saturated = 1'b1;
      end else if (s3_sum > $signed({2'b00, MAX_SERIAL})) begin
         s3_days_in.rem       = MAX_SERIAL - 17'd1;
         s3_days_in.saturated = 1'b1;
      end else begin
         s3_days_in.rem       = s3_sum[16:0] - 17'd1;
         s3_days_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_days_ff <= s3_days_in;
      end
   end

   dsdo_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_ready  (dec_ready),
      .in_data   (s3_days_ff),
      .out_valid (dec_valid),
      .out_ready (rsp_chan.ready),
      .out_data  (dec_result)
   );

   assign rsp_chan.valid      = dec_valid;
   assign rsp_chan.serial_day = dec_result.serial_day;
   assign rsp_chan.year_out   = dec_result.year_out;
   assign rsp_chan.month_out  = dec_result.month_out;
   assign rsp_chan.day_out    = dec_result.day_out;
   assign rsp_chan.saturated  = dec_result.saturated;

endmodule

// File: rtl/dsdo_decode.sv
`timescale 1ns / 1ps

module dsdo_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  dsdo_pkg::dsdo_days_type   in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output dsdo_pkg::dsdo_result_type out_data
);
   import dsdo_pkg::*;

   logic        d1_valid_ff, d2_valid_ff, d3_valid_ff, d4_valid_ff;
   logic        d1_ready, d2_ready, d3_ready, d4_ready;

   logic [34:0] d1_prod;
   logic [7:0]  d1_idx_in, d1_idx_ff;
   logic [16:0] d1_rem_ff, d1_serial_ff;
   logic        d1_sat_ff;

   logic [16:0] d2_start_in, d2_start_ff, d2_prev_in, d2_prev_ff;
   logic [7:0]  d2_idx_ff;
   logic [16:0] d2_rem_ff, d2_serial_ff;
   logic        d2_sat_ff;

   logic [7:0]  d3_idx_in, d3_idx_ff;
   logic [16:0] d3_base, d3_diff;
   logic [8:0]  d3_doy_in, d3_doy_ff;
   logic        d3_leap_in, d3_leap_ff;
   logic [16:0] d3_serial_ff;
   logic        d3_sat_ff;

   logic [3:0]  d4_month;
   logic [8:0]  d4_day_full;
   dsdo_result_type d4_result_in, d4_result_ff;

   assign d4_ready = ~d4_valid_ff | out_ready;
   assign d3_ready = ~d3_valid_ff | d4_ready;
   assign d2_ready = ~d2_valid_ff | d3_ready;
   assign d1_ready = ~d1_valid_ff | d2_ready;
   assign in_ready = d1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         d3_valid_ff <= 1'b0;
         d4_valid_ff <= 1'b0;
      end else begin
         if (d1_ready) d1_valid_ff <= in_valid;
         if (d2_ready) d2_valid_ff <= d1_valid_ff;
         if (d3_ready) d3_valid_ff <= d2_valid_ff;
         if (d4_ready) d4_valid_ff <= d3_valid_ff;
      end
   end

   // First guess of the year from the day count divided by 365.
   always_comb begin
      d1_prod   = 35'(in_data.rem) * 35'(RECIP_365);
      d1_idx_in = d1_prod[RECIP_SHIFT+7:RECIP_SHIFT];
      if (d1_idx_in > LAST_YEAR_IDX) begin
         d1_idx_in = LAST_YEAR_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (d1_ready && in_valid) begin
         d1_idx_ff    <= d1_idx_in;
         d1_rem_ff    <= in_data.rem;
         d1_serial_ff <= in_data.serial;
         d1_sat_ff    <= in_data.saturated;
      end
   end

   assign d2_start_in = year_start(d1_idx_ff);
   assign d2_prev_in  = year_start(d1_idx_ff - 8'd1);

   always_ff @(posedge clock) begin
      if (d2_ready && d1_valid_ff) begin
         d2_start_ff  <= d2_start_in;
         d2_prev_ff   <= d2_prev_in;
         d2_idx_ff    <= d1_idx_ff;
         d2_rem_ff    <= d1_rem_ff;
         d2_serial_ff <= d1_serial_ff;
         d2_sat_ff    <= d1_sat_ff;
      end
   end

   // The guess is at most one year too high.
   always_comb begin
      if (d2_start_ff > d2_rem_ff) begin
         d3_idx_in = d2_idx_ff - 8'd1;
         d3_base   = d2_prev_ff;
      end else begin
         d3_idx_in = d2_idx_ff;
         d3_base   = d2_start_ff;
      end
      d3_diff    = d2_rem_ff - d3_base;
      d3_doy_in  = d3_diff[8:0];
      d3_leap_in = year_leap(d3_idx_in);
   end

   always_ff @(posedge clock) begin
      if (d3_ready && d2_valid_ff) begin
         d3_idx_ff    <= d3_idx_in;
         d3_doy_ff    <= d3_doy_in;
         d3_leap_ff   <= d3_leap_in;
         d3_serial_ff <= d2_serial_ff;
         d3_sat_ff    <= d2_sat_ff;
      end
   end

   always_comb begin
      d4_month = MONTH_JAN;
      for (int m = 2; m <= 12; m++) begin
         if (d3_doy_ff >= month_start(4'(m), d3_leap_ff)) begin
            d4_month = 4'(m);
         end
      end
      d4_day_full             = d3_doy_ff - month_start(d4_month, d3_leap_ff) + 9'd1;
      d4_result_in.serial_day = d3_serial_ff;
      d4_result_in.year_out   = FIRST_YEAR + 12'(d3_idx_ff);
      d4_result_in.month_out  = d4_month;
      d4_result_in.day_out    = d4_day_full[4:0];
      d4_result_in.saturated  = d3_sat_ff;
   end

   always_ff @(posedge clock) begin
      if (d4_ready && d3_valid_ff) begin
         d4_result_ff <= d4_result_in;
      end
   end

   assign out_valid = d4_valid_ff;
   assign out_data  = d4_result_ff;

endmodule

// File: tb/date_serial_day_offset_tb.sv
`timescale 1ns / 1ps

module date_serial_day_offset_tb;
   import dsdo_pkg::*;

   localparam int REPAIR_YEAR = 2000;
   localparam int OFFSET_SPAN = 73048;
   localparam int LONG_HOLD_CYCLES = 80;

   class date_conversion_board;
      dsdo_result_type pending_dates[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      function bit leap_year(int y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int year_days(int y);
         return leap_year(y) ? 366 : 365;
      endfunction

      function int month_days(int y, int m);
         case (m)
            MONTH_FEB: return leap_year(y) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default: return 31;
         endcase
      endfunction

      function dsdo_result_type convert_date(logic [11:0] y_in, logic [3:0] m_in,
                                             logic [5:0] d_in, logic signed [17:0] off);
         int y, m, d, serial, total, rem, yy, mm, k;
         dsdo_result_type res;
         y = y_in;
         m = m_in;
         d = d_in;
         if (y < FIRST_YEAR || y > LAST_YEAR) y = REPAIR_YEAR;
         if (m < MONTH_JAN || m > MONTH_DEC) m = MONTH_JAN;
         if (d < 1 || d > month_days(y, m)) d = 1;
         serial = d;
         for (k = FIRST_YEAR; k < y; k++) serial += year_days(k);
         for (k = MONTH_JAN; k < m; k++) serial += month_days(y, k);
         total = serial + int'(off);
         res.saturated = 1'b0;
         if (total < 1) begin
            total = 1;
            res.saturated = 1'b1;
         end else if (total > MAX_SERIAL) begin
            total = MAX_SERIAL;
            res.saturated = 1'b1;
         end
         rem = total - 1;
         yy = FIRST_YEAR;
         while (rem >= year_days(yy)) begin
            rem -= year_days(yy);
            yy++;
         end
         mm = MONTH_JAN;
         while (rem >= month_days(yy, mm)) begin
            rem -= month_days(yy, mm);
            mm++;
         end
         res.serial_day = 17'(serial);
         res.year_out = 12'(yy);
         res.month_out = 4'(mm);
         res.day_out = 5'(rem + 1);
         return res;
      endfunction

      function void note_request(logic [11:0] y_in, logic [3:0] m_in, logic [5:0] d_in,
                                 logic signed [17:0] off);
         pending_dates.push_back(convert_date(y_in, m_in, d_in, off));
      endfunction

      function void check_result(dsdo_result_type got);
         dsdo_result_type want;
         if (pending_dates.size() == 0) begin
            $error("result transaction with no pending request");
            failures++;
            return;
         end
         want = pending_dates.pop_front();
         if (got.serial_day !== want.serial_day) begin
            $error("serial_day: expected %0d, got %0d", want.serial_day, got.serial_day);
            failures++;
         end
         if (got.year_out !== want.year_out) begin
            $error("year_out: expected %0d, got %0d", want.year_out, got.year_out);
            failures++;
         end
         if (got.month_out !== want.month_out) begin
            $error("month_out: expected %0d, got %0d", want.month_out, got.month_out);
            failures++;
         end
         if (got.day_out !== want.day_out) begin
            $error("day_out: expected %0d, got %0d", want.day_out, got.day_out);
            failures++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   burst_left;
   int   hold_asks;
   int   holds_served;
   date_conversion_board board;

   dsdo_req_if req_chan ();
   dsdo_rsp_if rsp_chan ();

   date_serial_day_offset u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   task automatic send_date(logic [11:0] y, logic [3:0] m, logic [5:0] d,
                            logic signed [17:0] off);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.year_in    <= y;
      req_chan.month_in   <= m;
      req_chan.day_in     <= d;
      req_chan.day_offset <= off;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_request(y, m, d, off);
   endtask

   task automatic send_random_date();
      int pick, y, m, d, serial, v;
      logic signed [17:0] off;
      dsdo_result_type base;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         send_date(12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)),
                   6'($urandom_range(0, 63)), 18'($urandom_range(0, 262143)));
         return;
      end
      if (pick < 35) y = ($urandom_range(0, 1) == 0) ? $urandom_range(1900, 1902)
                                                      : $urandom_range(2097, 2099);
      else y = $urandom_range(1900, 2099);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, board.month_days(y, m));
      base = board.convert_date(12'(y), 4'(m), 6'(d), 18'sd0);
      serial = base.serial_day;
      case ($urandom_range(0, 9))
         0, 1, 2: v = int'($urandom_range(0, 80)) - 40;
         3, 4, 5: v = int'($urandom_range(0, 2 * OFFSET_SPAN)) - OFFSET_SPAN;
         6:       v = int'($urandom_range(0, 262143));
         7:       v = 1 - serial + int'($urandom_range(0, 2)) - 1;
         8:       v = int'(MAX_SERIAL) - serial + int'($urandom_range(0, 2)) - 1;
         default: v = ($urandom_range(0, 1) == 0) ? 1 : -1;
      endcase
      off = 18'(v);
      send_date(12'(y), 4'(m), 6'(d), off);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.year_in = '0;
      req_chan.month_in = '0;
      req_chan.day_in = '0;
      req_chan.day_offset = '0;
      board = new();
      burst_left = 0;
      hold_asks = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_date(12'd1900, MONTH_JAN, 6'd1, 18'sd0);
      send_date(12'd1900, MONTH_JAN, 6'd2, -18'sd1);
      send_date(12'd1900, MONTH_JAN, 6'd2, -18'sd2);
      send_date(12'd2099, MONTH_DEC, 6'd31, 18'sd0);
      send_date(12'd2099, MONTH_DEC, 6'd31, 18'sd1);
      send_date(12'd2099, MONTH_DEC, 6'd30, 18'sd1);
      send_date(12'd1900, MONTH_JAN, 6'd1, 18'sd73048);
      send_date(12'd2099, MONTH_DEC, 6'd31, -18'sd73048);
      send_date(12'd2000, MONTH_JUN, 6'd15, 18'sh1FFFF);
      send_date(12'd2000, MONTH_JUN, 6'd15, 18'sh20000);
      send_date(12'd1999, MONTH_DEC, 6'd31, 18'sd1);
      send_date(12'd2000, MONTH_MAR, 6'd1, -18'sd1);
      send_date(12'd2000, MONTH_FEB, 6'd29, 18'sd0);
      send_date(12'd1900, MONTH_FEB, 6'd29, 18'sd0);
      send_date(12'd2100, MONTH_FEB, 6'd29, 18'sd0);
      send_date(12'd1899, MONTH_FEB, 6'd30, 18'sd0);
      send_date(12'd0, 4'd0, 6'd0, 18'sd0);
      send_date(12'd4095, 4'd15, 6'd63, -18'sd1);
      send_date(12'd2024, 4'd13, 6'd31, 18'sd365);
      send_date(12'd2023, MONTH_APR, 6'd31, 18'sd0);
      send_date(12'd2023, MONTH_DEC, 6'd31, 18'sd0);
      send_date(12'd2004, MONTH_FEB, 6'd28, 18'sd1);
      send_date(12'd1903, MONTH_FEB, 6'd28, 18'sd1);

      for (int i = 0; i < 650; i++) begin
         if (i == 150 || i == 420) hold_asks++;
         send_random_date();
      end
      req_chan.valid <= 1'b0;

      while (board.pending_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.failures == 0) begin
         $display("[date_serial_day_offset] OK");
      end else begin
         $display("[date_serial_day_offset] ERROR");
      end
      $finish;
   end

   initial begin
      int cycle_count;
      int hold_left;
      int stall_mode;
      dsdo_result_type got;
      rsp_chan.ready = 1'b0;
      holds_served = 0;
      cycle_count = 0;
      hold_left = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.serial_day = rsp_chan.serial_day;
            got.year_out = rsp_chan.year_out;
            got.month_out = rsp_chan.month_out;
            got.day_out = rsp_chan.day_out;
            got.saturated = rsp_chan.saturated;
            board.check_result(got);
         end
         cycle_count++;
         if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_left == 0 && holds_served < hold_asks) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 1) == 0);
               2:       rsp_chan.ready <= (cycle_count % 4 == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      #2_000_000;
      $display("[date_serial_day_offset] ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/dsdo_pkg.sv
rtl/dsdo_req_if.sv
rtl/dsdo_rsp_if.sv
rtl/dsdo_decode.sv
rtl/date_serial_day_offset.sv
tb/date_serial_day_offset_tb.sv
